### hw/rtl/rwaf_pkg.sv
// ----------------------------------------------------------------------------
// rwaf_pkg
// Shared sizes and helpers of the ring weighted average filter.
// ----------------------------------------------------------------------------
package rwaf_pkg;

  // item field widths
  localparam int SMP_FIELD_W = 16;
  localparam int WADDR_W     = 6;
  localparam int WVAL_W      = 16;
  localparam int FILT_W      = 16;
  localparam int TERMS_W     = 7;

  // ring geometry
  localparam int RING_DEPTH = 64;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 16;

  // datapath widths
  localparam int PROD_W = WEIGHT_W + SAMPLE_W + 1;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int WSUM_W = WEIGHT_W + CNT_W;
  localparam int QUO_W  = SAMPLE_W + 1;
  localparam int DCNT_W = $clog2(QUO_W);

  localparam int TERMS_MAX = (1 << TERMS_W) - 1;

  // clamp a term count to the width of the terms_used field
  function automatic logic [TERMS_W-1:0] sat_terms(input logic [CNT_W-1:0] t);
    logic [31:0] wide;
    wide = 32'(t);
    return (wide > 32'(TERMS_MAX)) ? TERMS_W'(TERMS_MAX) : wide[TERMS_W-1:0];
  endfunction

endpackage

### hw/rtl/rwaf_ifs.sv
// ----------------------------------------------------------------------------
// rwaf interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface rwaf_item_if import rwaf_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [SMP_FIELD_W-1:0] sample;
  logic [WADDR_W-1:0]          weight_addr;
  logic [WVAL_W-1:0]           weight_value;

  modport source (output valid, kind, sample, weight_addr, weight_value, input ready);
  modport sink   (input valid, kind, sample, weight_addr, weight_value, output ready);
endinterface

interface rwaf_result_if import rwaf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  logic [TERMS_W-1:0]       terms_used;
  logic                     zero_weight_sum;

  modport source (output valid, filtered, terms_used, zero_weight_sum, input ready);
  modport sink   (input valid, filtered, terms_used, zero_weight_sum, output ready);
endinterface

interface rwaf_cfg_if import rwaf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WVAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/rwaf_ram.sv
// ----------------------------------------------------------------------------
// rwaf_ram
// One write port, one registered read port; entries read as zero until written.
// ----------------------------------------------------------------------------
module rwaf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  // mark written entries, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_vld <= written[raddr];
    end
  end

  // storage array and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

### hw/rtl/rwaf_div.sv
// ----------------------------------------------------------------------------
// rwaf_div
// Serial restoring divider: signed sum over positive weight sum, one bit a cycle.
// ----------------------------------------------------------------------------
module rwaf_div import rwaf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [ACC_W-1:0]    dividend,
  input  logic [WSUM_W-1:0]          divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic              neg;
  logic [WSUM_W-1:0] rem;
  logic [QUO_W-1:0]  work;
  logic [WSUM_W-1:0] dsr;
  logic [ACC_W-1:0]  mag_in;
  logic [WSUM_W:0]   trial;
  logic [WSUM_W:0]   diff;
  logic              fits;
  logic [QUO_W-1:0]  q_signed;

  // magnitude of the dividend; quotient sign restored at the end
  assign mag_in = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);

  // one quotient bit per step
  assign trial = {rem, work[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[ACC_W-1];
      rem  <= WSUM_W'(mag_in >> QUO_W);
      work <= mag_in[QUO_W-1:0];
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= fits ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
      work <= {work[QUO_W-2:0], fits};
    end
  end

  assign q_signed = neg ? QUO_W'(-work) : work;
  assign quotient = q_signed[SAMPLE_W-1:0];

endmodule

### hw/rtl/ring_weighted_average_filter.sv
// ----------------------------------------------------------------------------
// ring_weighted_average_filter
// Weighted moving average over a ring of recent samples.
// ----------------------------------------------------------------------------
// Channels: items (sink) carries kind, sample, weight_addr and weight_value;
// results (source) carries filtered, terms_used and zero_weight_sum; cfg
// (sink) writes min_weight and is always ready.
// A weight item (kind 1) writes one entry of the weight memory in the cycle
// it is accepted and gives no result. A sample item (kind 0) is stored in
// the next ring slot, then the sequencer walks back through the ring, one
// term per cycle from the sample and weight memories, multiply, then
// accumulate. Once the walk ends, the pipeline drains, the serial divider
// runs and the result is handed to the output register; a full lap walks
// 64 terms. A zero weight sum skips the divider.
// One item is in work at a time; items.ready is high only when idle. The
// result sits in an output register, so the next item is taken while it
// waits. If the receiver stalls with that register full, the next result
// holds in the sequencer until the register empties.
// Reset clears min_weight, the newest slot pointer and the written marks of
// both memories, so all samples and weights read as zero.
// ----------------------------------------------------------------------------
module ring_weighted_average_filter import rwaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rwaf_item_if.sink   items,
  rwaf_cfg_if.sink    cfg,
  rwaf_result_if.source results
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                state;
  logic [WEIGHT_W-1:0]       min_weight;
  logic [ADDR_W-1:0]         newest_slot;
  logic [ADDR_W-1:0]         slot_inc;
  logic                      item_acc;
  logic                      addr_ok;

  logic [CNT_W-1:0]          rd_idx;
  logic [ADDR_W-1:0]         rd_slot;
  logic                      issue;
  logic                      p1_vld;
  logic [CNT_W-1:0]          p1_idx;
  logic                      p2_vld;
  logic [WEIGHT_W-1:0]       w_rdata;
  logic [SAMPLE_W-1:0]       s_rdata;
  logic                      stop;
  logic                      last;
  logic                      end_walk;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic [WSUM_W-1:0]         wsum;
  logic [CNT_W-1:0]          taken;

  logic                      div_start;
  logic                      div_done;
  logic signed [SAMPLE_W-1:0] div_q;

  logic signed [FILT_W-1:0]  res_filtered;
  logic                      res_zero;
  logic                      out_load;
  logic                      out_vld;
  logic signed [FILT_W-1:0]  out_filtered;
  logic [TERMS_W-1:0]        out_terms;
  logic                      out_zero;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_weight <= '0;
    end else if (cfg.valid) begin
      min_weight <= WEIGHT_W'(cfg.data);
    end
  end

  // input handshake and write addresses
  assign items.ready = (state == S_IDLE);
  assign item_acc    = items.valid && items.ready;
  assign slot_inc    = (newest_slot == ADDR_W'(RING_DEPTH - 1)) ? '0 : newest_slot + 1'b1;
  assign addr_ok     = (32'(items.weight_addr) < 32'(RING_DEPTH));

  rwaf_ram #(.DEPTH(RING_DEPTH), .WIDTH(SAMPLE_W)) u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (item_acc && !items.kind),
    .waddr (slot_inc),
    .wdata (SAMPLE_W'(items.sample)),
    .raddr (rd_slot),
    .rdata (s_rdata)
  );

  rwaf_ram #(.DEPTH(RING_DEPTH), .WIDTH(WEIGHT_W)) u_weights (
    .clk   (clk),
    .rst   (rst),
    .we    (item_acc && items.kind && addr_ok),
    .waddr (ADDR_W'(items.weight_addr)),
    .wdata (WEIGHT_W'(items.weight_value)),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (w_rdata)
  );

  // walk control: a read issues each cycle, its data checked in the next cycle
  assign issue    = (state == S_WALK) && (rd_idx < CNT_W'(RING_DEPTH));
  assign stop     = (p1_idx != '0) && (w_rdata < min_weight);
  assign last     = (p1_idx == CNT_W'(RING_DEPTH - 1));
  assign end_walk = p1_vld && (stop || last);

  assign out_load = (state == S_OUT) && (!out_vld || results.ready);

  // sequencer, pipeline valids and output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      newest_slot <= '0;
      p1_vld      <= 1'b0;
      p2_vld      <= 1'b0;
      div_start   <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      p1_vld    <= issue && !end_walk;
      p2_vld    <= p1_vld && !stop;
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc && !items.kind) begin
            newest_slot <= slot_inc;
            state       <= S_WALK;
          end
        end
        S_WALK: begin
          if (end_walk) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!p2_vld) begin
            if (wsum == '0) begin
              state <= S_OUT;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath: addresses, multiply, accumulate, result hold
  always_ff @(posedge clk) begin
    if (item_acc && !items.kind) begin
      rd_idx  <= '0;
      rd_slot <= slot_inc;
      acc     <= '0;
      wsum    <= '0;
      taken   <= '0;
    end else begin
      if (issue) begin
        rd_idx  <= rd_idx + 1'b1;
        rd_slot <= (rd_slot == '0) ? ADDR_W'(RING_DEPTH - 1) : rd_slot - 1'b1;
      end
      if (p1_vld && !stop) begin
        wsum  <= wsum + WSUM_W'(w_rdata);
        taken <= p1_idx + 1'b1;
      end
      if (p2_vld) begin
        acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
    p1_idx <= rd_idx;
    prod   <= $signed({1'b0, w_rdata}) * $signed(s_rdata);
    if ((state == S_DRAIN) && !p2_vld && (wsum == '0)) begin
      res_filtered <= '0;
      res_zero     <= 1'b1;
    end else if ((state == S_DIV) && div_done) begin
      res_filtered <= FILT_W'(div_q);
      res_zero     <= 1'b0;
    end
    if (out_load) begin
      out_filtered <= res_filtered;
      out_terms    <= sat_terms(taken);
      out_zero     <= res_zero;
    end
  end

  rwaf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (wsum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign results.valid           = out_vld;
  assign results.filtered        = out_filtered;
  assign results.terms_used      = out_terms;
  assign results.zero_weight_sum = out_zero;

  // checks on the sequencer
  a_idle_clean : assert property (@(posedge clk) disable iff (rst)
    items.ready |-> (!p1_vld && !p2_vld))
    else $error("walk pipeline busy while idle");

  a_p1_in_walk : assert property (@(posedge clk) disable iff (rst)
    p1_vld |-> (state == S_WALK))
    else $error("read data returned outside the walk");

  a_div_done_state : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_zero_forces_zero : assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.zero_weight_sum) |-> (results.filtered == '0))
    else $error("zero weight sum with nonzero output");

  a_terms_nonzero : assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.terms_used != '0))
    else $error("result without any term");

endmodule

### dv/rwaf_avg_check.sv
// ----------------------------------------------------------------------------
// rwaf_avg_check
// Watches the item, register and result channels of the ring weighted
// average filter, keeps its own copy of the ring, weights and threshold,
// predicts one average per accepted sample item and compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rwaf_avg_check import rwaf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  rwaf_item_if   items,
  rwaf_cfg_if    cfg,
  rwaf_result_if results,
  output int     mismatches,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic [TERMS_W-1:0]       terms;
    logic                     zero_sum;
  } avg_t;

  // shadow state of the filter
  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [WEIGHT_W-1:0]        wtab [RING_DEPTH];
  logic [ADDR_W-1:0]          newest;
  logic [WEIGHT_W-1:0]        min_w;

  avg_t expected_avgs [$];
  int   fail_tally = 0;

  // print one line and count; keep the log short on a broken design
  task automatic report_mismatch(input string msg);
    if (fail_tally < 100) $display("[%0t] mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  task automatic clear_model();
    for (int k = 0; k < RING_DEPTH; k++) begin
      ring[k] = '0;
      wtab[k] = '0;
    end
    newest = '0;
    min_w  = '0;
    expected_avgs.delete();
  endtask

  // apply one item: a weight write, or a sample push and its backward walk
  task automatic filter_item(input logic kind, input logic signed [SMP_FIELD_W-1:0] smp,
                             input logic [WADDR_W-1:0] addr,
                             input logic [WVAL_W-1:0] wval);
    longint acc, wsum, quo;
    int     taken;
    logic   more;
    logic [ADDR_W-1:0] slot;
    avg_t   avg;
    if (kind) begin
      wtab[addr] = wval;
    end else begin
      newest       = (newest == ADDR_W'(RING_DEPTH - 1)) ? '0 : newest + 1'b1;
      ring[newest] = smp;
      slot  = newest;
      taken = 0;
      acc   = 0;
      wsum  = 0;
      // first term is always taken; stop after a lap or on a light weight
      do begin
        acc   += longint'(wtab[taken]) * longint'(ring[slot]);
        wsum  += longint'(wtab[taken]);
        taken++;
        slot  = (slot == '0) ? ADDR_W'(RING_DEPTH - 1) : slot - 1'b1;
        more  = (slot != newest) && (taken < RING_DEPTH);
        if (more) more = (wtab[taken] >= min_w);
      end while (more);
      if (wsum == 0) begin
        avg.filtered = '0;
        avg.zero_sum = 1'b1;
      end else begin
        quo          = acc / wsum;
        avg.filtered = quo[FILT_W-1:0];
        avg.zero_sum = 1'b0;
      end
      avg.terms = (taken > TERMS_MAX) ? TERMS_W'(TERMS_MAX) : TERMS_W'(taken);
      expected_avgs.push_back(avg);
    end
  endtask

  // compare one result against the oldest prediction
  task automatic check_average(input avg_t got);
    avg_t want;
    if (expected_avgs.size() == 0) begin
      report_mismatch($sformatf("result with no sample item waiting (filtered %0d)",
                                got.filtered));
    end else begin
      want = expected_avgs.pop_front();
      if (got.filtered !== want.filtered)
        report_mismatch($sformatf("filtered %0d, predicted %0d", got.filtered,
                                  want.filtered));
      if (got.terms !== want.terms)
        report_mismatch($sformatf("terms_used %0d, predicted %0d", got.terms, want.terms));
      if (got.zero_sum !== want.zero_sum)
        report_mismatch($sformatf("zero_weight_sum %b, predicted %b", got.zero_sum,
                                  want.zero_sum));
    end
  endtask

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (cfg.valid && cfg.ready) min_w = cfg.data;
      if (results.valid && results.ready)
        check_average('{results.filtered, results.terms_used, results.zero_weight_sum});
      if (items.valid && items.ready)
        filter_item(items.kind, items.sample, items.weight_addr, items.weight_value);
    end
    pending    <= expected_avgs.size();
    mismatches <= fail_tally;
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the ring weighted average filter bench: drives directed and random
// sample and weight items under several threshold settings and idle
// patterns, lets the averaging check judge the results and gives the verdict.
// ----------------------------------------------------------------------------
module tb import rwaf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst;
  int   src_idle;
  int   sink_idle;
  int   mismatches;
  int   avgs_pending;

  rwaf_item_if   items_if ();
  rwaf_result_if results_if ();
  rwaf_cfg_if    cfg_if ();

  ring_weighted_average_filter uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .cfg     (cfg_if),
    .results (results_if)
  );

  rwaf_avg_check avg_check (
    .clk        (clk),
    .rst        (rst),
    .items      (items_if),
    .cfg        (cfg_if),
    .results    (results_if),
    .mismatches (mismatches),
    .pending    (avgs_pending)
  );

  always #10 clk = ~clk;

  // receiver: stall at random
  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(99) >= sink_idle);
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // hold valid until the item is taken, idling at random before it
  task automatic send_item(input logic kind, input logic signed [SMP_FIELD_W-1:0] smp,
                           input logic [WADDR_W-1:0] addr, input logic [WVAL_W-1:0] wval);
    while ($urandom_range(99) < src_idle) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.kind         <= kind;
    items_if.sample       <= smp;
    items_if.weight_addr  <= addr;
    items_if.weight_value <= wval;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
  endtask

  // wait until every average is back and the block has gone quiet
  task automatic settle();
    items_if.valid <= 1'b0;
    @(posedge clk);
    while (avgs_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_min_weight(input logic [WVAL_W-1:0] v);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [SMP_FIELD_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return SMP_FIELD_W'($urandom);
    endcase
  endfunction

  function automatic logic [WVAL_W-1:0] pick_weight();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      default: return WVAL_W'($urandom_range(32768));
    endcase
  endfunction

  // weight profile for entry k: linear decay, any pattern, halving, or sparse
  function automatic logic [WVAL_W-1:0] weight_shape(input int k, input int style,
                                                     input int step);
    int v;
    case (style)
      0: begin
        v = 32768 - k * step;
        return (v < 0) ? '0 : WVAL_W'(v);
      end
      1:       return WVAL_W'($urandom);
      2:       return WVAL_W'(32768 >> (k / 4));
      default: return ($urandom_range(3) == 0) ? WVAL_W'($urandom_range(32768)) : '0;
    endcase
  endfunction

  initial begin
    int src_modes [3];
    int sink_modes [3];
    logic [WVAL_W-1:0] mins [6];
    int mode;
    int half;
    int k;
    int n;
    int style;
    int step;

    src_modes  = '{29, 73, 0};
    sink_modes = '{73, 29, 0};
    mins       = '{16'd32768, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0};
    mins[3]    = WVAL_W'($urandom_range(32768));
    mins[5]    = WVAL_W'($urandom);
    src_idle   = src_modes[0];
    sink_idle  = sink_modes[0];

    // drive every input from time zero, hold reset
    rst                   <= 1'b1;
    items_if.valid        <= 1'b0;
    items_if.kind         <= 1'b0;
    items_if.sample       <= '0;
    items_if.weight_addr  <= '0;
    items_if.weight_value <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.data           <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero weight sum, extremes, weight above 1.0, first term always taken
    set_min_weight(16'd0);
    send_item(1'b0, 16'sh7FFF, 6'h3F, 16'hFFFF);
    send_item(1'b0, 16'sh8000, 6'h00, 16'h0000);
    send_item(1'b1, 16'sh7FFF, 6'h00, 16'd32768);
    send_item(1'b0, 16'sh7FFF, 6'h00, 16'h0000);
    send_item(1'b0, 16'sh8000, 6'h00, 16'h0000);
    send_item(1'b1, 16'shFFFF, 6'h3F, 16'hFFFF);
    send_item(1'b1, 16'sh0000, 6'h01, 16'd1);
    send_item(1'b0, -16'sd1, 6'h2A, 16'h5555);
    send_item(1'b0, 16'sd1, 6'h15, 16'hAAAA);
    send_item(1'b0, 16'sd0, 6'h00, 16'h0000);
    send_item(1'b0, 16'sh5555, 6'h3F, 16'hFFFF);
    send_item(1'b0, 16'shAAAA, 6'h00, 16'h0000);
    send_item(1'b1, 16'sh5555, 6'h2A, 16'h5555);
    send_item(1'b1, 16'shAAAA, 6'h15, 16'hAAAA);
    send_item(1'b0, 16'sd12345, 6'h00, 16'h0000);
    send_item(1'b1, 16'sh0000, 6'h00, 16'h0000);
    send_item(1'b0, 16'sd12345, 6'h00, 16'h0000);
    // threshold above the second weight: the walk ends after the first term
    set_min_weight(16'd32768);
    send_item(1'b0, -16'sd4321, 6'h00, 16'h0000);
    send_item(1'b1, 16'sh0000, 6'h00, 16'd32768);
    send_item(1'b0, 16'sd777, 6'h00, 16'h0000);
    send_item(1'b0, 16'sh7FFF, 6'h00, 16'h0000);

    // random: load a weight profile, then mostly samples with a few rewrites
    for (mode = 0; mode < 3; mode++) begin
      src_idle  = src_modes[mode];
      sink_idle = sink_modes[mode];
      for (half = 0; half < 2; half++) begin
        set_min_weight(mins[2 * mode + half]);
        style = $urandom_range(3);
        step  = $urandom_range(1, 1024);
        for (k = 0; k < RING_DEPTH; k++)
          send_item(1'b1, SMP_FIELD_W'($urandom), WADDR_W'(k), weight_shape(k, style, step));
        for (n = 0; n < 125; n++) begin
          if ($urandom_range(9) < 2)
            send_item(1'b1, SMP_FIELD_W'($urandom), WADDR_W'($urandom_range(63)),
                      pick_weight());
          else
            send_item(1'b0, pick_sample(), WADDR_W'($urandom), WVAL_W'($urandom));
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
